// ===== sv/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the triangle sphere projector
// Coordinate, division and square-root widths, and the cell payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

	localparam int COORD_W     = 16;
	localparam int VERTS       = 3;
	localparam int AXES        = 3;
	localparam int Q_W         = 32;           // exact quadrance, Q8.24
	localparam int QUO_W       = 48;           // quotient bits kept below saturation
	localparam int NUM_SHIFT   = 44;           // squared radius << 44
	localparam int SQ_W        = 16;           // squared radius width
	localparam int SAT_SHIFT   = QUO_W - NUM_SHIFT;
	localparam int ROOT_W      = QUO_W / 2;    // ratio, Q8.16
	localparam int SREM_W      = ROOT_W + 1;
	localparam int DIV_STEPS   = QUO_W;
	localparam int SQRT_STEPS  = ROOT_W;
	localparam int FRAC_SHIFT  = 16;
	localparam int PROD_W      = COORD_W + ROOT_W + 1;
	localparam int DATA_W      = VERTS * AXES * COORD_W;
	localparam logic [SQ_W-1:0] SPHERE_RESET = 16'd14819;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} vtx_t;

	typedef struct packed {
		logic [Q_W-1:0]   rem;
		logic [QUO_W-1:0] quo;
		logic [Q_W-1:0]   q;
		logic             sat;
		vtx_t             v;
	} div_t;

	typedef struct packed {
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
		logic [QUO_W-1:0]  m;
		logic              sat;
		vtx_t              v;
	} sqrt_t;

endpackage

`default_nettype wire

// ===== sv/tsp_div_cell.sv =====
// ----------------------------------------------------------------------------
// tsp_div_cell: one restoring division step
// Shifts in one numerator bit, subtracts the divisor when it fits and
// appends one quotient bit; hands the vertex on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_div_cell import tsp_pkg::*; (
	input  logic clk,
	input  logic en,
	input  logic num_bit,
	input  div_t d_in,
	output div_t d_out
);

	logic [Q_W:0] rem_ext;
	logic [Q_W:0] diff;
	logic         ge;

	// trial subtract of the divisor
	assign rem_ext = {d_in.rem, num_bit};
	assign diff    = rem_ext - {1'b0, d_in.q};
	assign ge      = rem_ext >= {1'b0, d_in.q};

	// advance the step
	always_ff @(posedge clk) begin
		if (en) begin
			d_out.rem <= ge ? diff[Q_W-1:0] : rem_ext[Q_W-1:0];
			d_out.quo <= {d_in.quo[QUO_W-2:0], ge};
			d_out.q   <= d_in.q;
			d_out.sat <= d_in.sat;
			d_out.v   <= d_in.v;
		end
	end

endmodule

`default_nettype wire

// ===== sv/tsp_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tsp_sqrt_cell: one digit step of the integer square root
// Takes two radicand bits, tries root*4+1 against the partial remainder and
// appends one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_sqrt_cell import tsp_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  sqrt_t s_in,
	output sqrt_t s_out
);

	logic [SREM_W+1:0] rem_ext;
	logic [SREM_W+1:0] trial;
	logic [SREM_W+1:0] diff;
	logic              ge;

	// trial subtract of root*4+1
	assign rem_ext = {s_in.rem, s_in.m[QUO_W-1:QUO_W-2]};
	assign trial   = {1'b0, s_in.root, 2'b01};
	assign diff    = rem_ext - trial;
	assign ge      = rem_ext >= trial;

	// advance the step
	always_ff @(posedge clk) begin
		if (en) begin
			s_out.rem  <= ge ? diff[SREM_W-1:0] : rem_ext[SREM_W-1:0];
			s_out.root <= {s_in.root[ROOT_W-2:0], ge};
			s_out.m    <= {s_in.m[QUO_W-3:0], 2'b00};
			s_out.sat  <= s_in.sat;
			s_out.v    <= s_in.v;
		end
	end

endmodule

`default_nettype wire

// ===== sv/triangle_sphere_projector.sv =====
// ----------------------------------------------------------------------------
// triangle_sphere_projector: radial projection of a triangle onto a sphere
// Input items carry three Q3.12 vertices; each vertex is scaled by
// sqrt(radius_sq / q) in Q8.16 and the result saturated to Q3.12.
//
// Usage:
//  - s_* channel takes one triangle per item; m_* channel gives one projected
//    triangle per item. A triangle with a vertex at the origin gives no item.
//  - cfg_* channel writes the squared sphere radius (Q4.12); cfg_ready is
//    always high. Write it only while no item is in flight.
//  - An item passes three front stages (register, square, sum), 48 division
//    cells, 24 square-root cells, one multiply stage and the output
//    register. Throughput is one item per cycle unless a stalled receiver
//    freezes the chain; the three vertices run in parallel lanes of cells.
//  - Reset clears all valid bits and loads the squared radius with 14819.
//  - When the receiver stalls, the output register holds; the cell chain
//    keeps moving while its last stage is empty and freezes once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_sphere_projector import tsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (lowest first)
	input  logic [DATA_W-1:0] s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// proj_a_x .. proj_c_z in the same order (lowest first)
	output logic [DATA_W-1:0] m_tdata,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SQ_W-1:0]   cfg_data
);

	localparam int PIPE = 3 + DIV_STEPS + SQRT_STEPS + 1;

	logic [SQ_W-1:0]   sphere_q;
	logic [PIPE-1:0]   valid_q;
	logic [PIPE-1:0]   valid_nx;
	logic              advance;
	logic              nonzero;
	logic              tvalid_q;
	logic [DATA_W-1:0] tdata_q;

	vtx_t              vtx_s1 [VERTS];
	vtx_t              vtx_s2 [VERTS];
	vtx_t              vtx_s3 [VERTS];
	logic [Q_W-1:0]    sqx_s2 [VERTS];
	logic [Q_W-1:0]    sqy_s2 [VERTS];
	logic [Q_W-1:0]    sqz_s2 [VERTS];
	logic [Q_W-1:0]    q_s3   [VERTS];
	logic [Q_W+1:0]    qsum   [VERTS];
	logic [VERTS-1:0]  qnz;
	logic signed [PROD_W-1:0] prod_s4 [VERTS][AXES];
	logic [DATA_W-1:0] sat_out;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_q <= SPHERE_RESET;
		end else if (cfg_valid) begin
			sphere_q <= cfg_data;
		end
	end

	// move the chain unless a full last stage meets a stalled output
	assign advance  = !valid_q[PIPE-1] || !tvalid_q || m_tready;
	assign s_tready = advance;

	// front stages: register, square, sum
	always_comb begin
		for (int i = 0; i < VERTS; i++) begin
			qsum[i] = {2'b00, sqx_s2[i]} + {2'b00, sqy_s2[i]} + {2'b00, sqz_s2[i]};
			qnz[i]  = qsum[i] != '0;
		end
	end
	assign nonzero = &qnz;

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < VERTS; i++) begin
				vtx_s1[i] <= s_tdata[i*AXES*COORD_W +: AXES*COORD_W];
				vtx_s2[i] <= vtx_s1[i];
				sqx_s2[i] <= Q_W'($signed(vtx_s1[i].x) * $signed(vtx_s1[i].x));
				sqy_s2[i] <= Q_W'($signed(vtx_s1[i].y) * $signed(vtx_s1[i].y));
				sqz_s2[i] <= Q_W'($signed(vtx_s1[i].z) * $signed(vtx_s1[i].z));
				vtx_s3[i] <= vtx_s2[i];
				q_s3[i]   <= qsum[i][Q_W-1:0];
			end
		end
	end

	// valid bits; drop triangles with a vertex at the origin
	always_comb begin
		valid_nx    = {valid_q[PIPE-2:0], s_tvalid};
		valid_nx[2] = valid_q[1] && nonzero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (advance) begin
			valid_q <= valid_nx;
		end
	end

	// one lane of cells per vertex
	for (genvar i = 0; i < VERTS; i++) begin : g_lane
		div_t  dch [DIV_STEPS+1];
		sqrt_t sch [SQRT_STEPS+1];
		logic [ROOT_W-1:0] ratio;

		// lane entry: a quotient of 2^48 or more saturates the ratio
		always_comb begin
			dch[0].rem = {{(Q_W-SQ_W+SAT_SHIFT){1'b0}}, sphere_q[SQ_W-1:SAT_SHIFT]};
			dch[0].quo = '0;
			dch[0].q   = q_s3[i];
			dch[0].sat = {{(Q_W+SAT_SHIFT-SQ_W){1'b0}}, sphere_q} >=
				{q_s3[i], {SAT_SHIFT{1'b0}}};
			dch[0].v   = vtx_s3[i];
		end

		for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
			localparam int BIT = QUO_W - 1 - j;
			logic nb;
			if (BIT >= NUM_SHIFT) begin : g_sbit
				assign nb = sphere_q[BIT-NUM_SHIFT];
			end else begin : g_zbit
				assign nb = 1'b0;
			end
			tsp_div_cell u_div (
				.clk     (clk),
				.en      (advance),
				.num_bit (nb),
				.d_in    (dch[j]),
				.d_out   (dch[j+1])
			);
		end

		always_comb begin
			sch[0].rem  = '0;
			sch[0].root = '0;
			sch[0].m    = dch[DIV_STEPS].quo;
			sch[0].sat  = dch[DIV_STEPS].sat;
			sch[0].v    = dch[DIV_STEPS].v;
		end

		for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
			tsp_sqrt_cell u_sqrt (
				.clk   (clk),
				.en    (advance),
				.s_in  (sch[j]),
				.s_out (sch[j+1])
			);
		end

		assign ratio = sch[SQRT_STEPS].sat ? '1 : sch[SQRT_STEPS].root;

		// scale each coordinate by the ratio
		always_ff @(posedge clk) begin
			if (advance) begin
				prod_s4[i][0] <= $signed(sch[SQRT_STEPS].v.x) * $signed({1'b0, ratio});
				prod_s4[i][1] <= $signed(sch[SQRT_STEPS].v.y) * $signed({1'b0, ratio});
				prod_s4[i][2] <= $signed(sch[SQRT_STEPS].v.z) * $signed({1'b0, ratio});
			end
		end
	end

	// floor to Q3.12 and saturate
	always_comb begin
		logic signed [PROD_W-1:0] sh;
		for (int i = 0; i < VERTS; i++) begin
			for (int k = 0; k < AXES; k++) begin
				sh = prod_s4[i][k] >>> FRAC_SHIFT;
				if (sh > $signed(PROD_W'(32767))) begin
					sat_out[(i*AXES+k)*COORD_W +: COORD_W] = 16'h7FFF;
				end else if (sh < -$signed(PROD_W'(32768))) begin
					sat_out[(i*AXES+k)*COORD_W +: COORD_W] = 16'h8000;
				end else begin
					sat_out[(i*AXES+k)*COORD_W +: COORD_W] = sh[COORD_W-1:0];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (advance && valid_q[PIPE-1]) begin
			tvalid_q <= 1'b1;
		end else if (m_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_q[PIPE-1]) begin
			tdata_q <= sat_out;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;

endmodule

`default_nettype wire

// ===== sv/tsp_checker.sv =====
// ----------------------------------------------------------------------------
// tsp_checker: port-level checks of the triangle sphere projector
// Watches the stream and configuration ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_checker import tsp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic              cfg_ready
);

	// a stalled output item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	// input stalls only behind a stalled output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// configuration is always taken
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration channel not ready");

	// reset empties the output by the next edge
	a_rst: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("output valid after reset");

endmodule

bind triangle_sphere_projector tsp_checker u_tsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_ready (cfg_ready)
);

`default_nettype wire
